// ===== hdl/sadf_pkg.sv =====
// Shared constants, register indexes and helpers of the slew adaptive distance filter.
package sadf_pkg;

  localparam int DELAY_DEPTH = 128;
  localparam int DLY_W       = $clog2(DELAY_DEPTH);
  localparam int NUM_STAGES  = 3;
  localparam int STG_W       = 2;
  localparam int ADDR_W      = STG_W + DLY_W;
  localparam int STORE_DEPTH = NUM_STAGES * DELAY_DEPTH;

  localparam int SAMPLE_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SLEW_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_OUT_SLEW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SLEW_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LEVEL_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX        = 3'd5;

  localparam logic [25:0] RST_SLEW_GAIN      = 26'd32768;
  localparam logic [25:0] RST_INV_OUT_SLEW   = 26'd131072;
  localparam logic [25:0] RST_INV_SLEW_GAIN  = 26'd131072;
  localparam logic [25:0] RST_LEVEL_GAIN     = 26'd125829;
  localparam logic [31:0] RST_INV_LEVEL_GAIN = 32'd8738133;
  localparam logic [16:0] RST_WET_MIX        = 17'd65536;

  localparam logic [46:0] MAX48_MAG   = 47'h7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] CLAMP_LEVEL = 48'sd953482740;
  localparam logic signed [47:0] HALF32 = 48'sh0000_8000_0000;
  localparam logic [47:0] ONE32 = 48'h0001_0000_0000;

  // Saturate a wide signed sum to the symmetric 48-bit range.
  function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
    logic signed [57:0] lim;
    lim = 58'(MAX48);
    if (v > lim) begin
      return MAX48;
    end else if (v < -lim) begin
      return -MAX48;
    end else begin
      return v[47:0];
    end
  endfunction

endpackage

// ===== hdl/sadf_if.sv =====
// Stream interfaces for the sample words into and out of the filter.
interface sadf_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [23:0]   sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface sadf_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [23:0]   sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== hdl/sadf_div.sv =====
// Restoring divider, one quotient bit per cycle: floor(num * 2^32 / den).
module sadf_div import sadf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [47:0] quo
);

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [47:0] rem_r;
  logic [47:0] den_r;
  logic [79:0] dvd_r;
  logic [47:0] quo_r;
  logic [48:0] trial;
  logic        ge;

  assign trial = {rem_r, dvd_r[79]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        den_r  <= den;
        dvd_r  <= {num, 32'b0};
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? 48'(trial - {1'b0, den_r}) : trial[47:0];
        dvd_r <= {dvd_r[78:0], 1'b0};
        quo_r <= {quo_r[46:0], ge};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/slew_adaptive_distance_filter_top.sv =====
// Three-stage slew adaptive distance filter: sequencer, shared multiplier and delay memory.
// Each stage runs a serial divide and five multiplies on the shared multiplier; a partial wet
// mix adds two more. A word is taken only while idle, so the next word waits until the result
// is loaded into the output register, which waits while the output stalls.
// After reset a clearing pass zeroes the delay memory before the first word is
// taken; configuration registers return to their defaults at once.
module slew_adaptive_distance_filter_top import sadf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sadf_in_if.sink               in_ch,
  sadf_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_V    = 5'd2;
  localparam logic [4:0] ST_D    = 5'd3;
  localparam logic [4:0] ST_PF   = 5'd4;
  localparam logic [4:0] ST_U    = 5'd5;
  localparam logic [4:0] ST_E    = 5'd6;
  localparam logic [4:0] ST_DIV  = 5'd7;
  localparam logic [4:0] ST_Y    = 5'd8;
  localparam logic [4:0] ST_W    = 5'd9;
  localparam logic [4:0] ST_W2   = 5'd10;
  localparam logic [4:0] ST_P    = 5'd11;
  localparam logic [4:0] ST_R1   = 5'd12;
  localparam logic [4:0] ST_R2   = 5'd13;
  localparam logic [4:0] ST_R3   = 5'd14;
  localparam logic [4:0] ST_I1   = 5'd15;
  localparam logic [4:0] ST_I2   = 5'd16;
  localparam logic [4:0] ST_I3   = 5'd17;
  localparam logic [4:0] ST_NEXT = 5'd18;
  localparam logic [4:0] ST_M1   = 5'd19;
  localparam logic [4:0] ST_M2   = 5'd20;
  localparam logic [4:0] ST_OUT  = 5'd21;
  localparam logic [4:0] ST_MA   = 5'd22;
  localparam logic [4:0] ST_MB   = 5'd23;
  localparam logic [4:0] ST_MC   = 5'd24;

  localparam logic [1:0] SH16 = 2'd0;
  localparam logic [1:0] SH24 = 2'd1;
  localparam logic [1:0] SH33 = 2'd2;

  localparam logic [55:0] LIM16 = 56'(MAX48_MAG >> 8);

  // Configuration registers.
  logic [25:0] slew_r, ios_r, isg_r, lvl_r;
  logic [31:0] ilg_r;
  logic [16:0] wet_r;

  // Per-stage state.
  logic signed [47:0] last_in_r [NUM_STAGES];
  logic signed [47:0] diff_r    [NUM_STAGES];
  logic signed [47:0] sm_r      [NUM_STAGES];
  logic [31:0]        pos_r     [NUM_STAGES];
  logic [DLY_W-1:0]   wp_r      [NUM_STAGES];

  // Sequencer and datapath registers.
  logic [4:0]         state_r, ret_r;
  logic [STG_W-1:0]   stg_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic signed [47:0] x_r, dry_r, v_r, nd_r, pf_r, e_r, w_r, m1_r;
  logic signed [48:0] dd_r;
  logic [DLY_W-1:0]   dly_r;
  logic [31:0]        frac_r;
  logic signed [23:0] tap1_r;
  logic signed [24:0] dif_r;
  logic [23:0]        dmag_r;
  logic               dneg_r;
  logic [55:0]        prod_r;
  logic               out_valid_r;
  logic signed [23:0] out_data_r;

  // Shared multiply pass.
  logic signed [47:0] mq_a_r;
  logic [31:0]        mq_b_r;
  logic [1:0]         mq_sh_r;
  logic [55:0]        hi_r, lo_r;
  logic signed [47:0] mq_res_r;

  // Delay memory.
  logic signed [23:0] mem [STORE_DEPTH];
  logic signed [23:0] rd_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa, mem_ra;
  logic signed [23:0] mem_wd;

  // Divider hookup.
  logic               div_start, div_done;
  logic [47:0]        div_num, div_den, div_quo;

  // Combinational helpers.
  logic [47:0]        mq_m;
  logic [23:0]        mul_x;
  logic [31:0]        mul_y;
  logic [55:0]        mul_p;
  logic [56:0]        rs, r16, rsel;
  logic [46:0]        rmag;
  logic signed [47:0] mq_comb;
  logic signed [49:0] dd_abs;
  logic signed [47:0] pf_comb, y_comb, w_clamp, wq, o_sh;
  logic [31:0]        b_term, pos_new;
  logic signed [57:0] z_full;
  logic signed [47:0] z_comb;
  logic signed [47:0] dry_comb;
  logic [DLY_W-1:0]   i1;

  assign mq_m  = mq_a_r[47] ? 48'(-mq_a_r) : mq_a_r;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_r)
      ST_MA: begin
        mul_x = {1'b0, mq_m[46:24]};
        mul_y = mq_b_r;
      end
      ST_MB: begin
        mul_x = mq_m[23:0];
        mul_y = mq_b_r;
      end
      ST_I2: begin
        mul_x = dmag_r;
        mul_y = frac_r;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = 56'(mul_x) * 56'(mul_y);

  // Recombine the two partial products, shift, saturate and restore the sign.
  always_comb begin
    rs  = 57'(hi_r) + 57'(lo_r[55:24]);
    r16 = (hi_r > LIM16) ? 57'(MAX48_MAG) : ((57'(hi_r) << 8) + 57'(lo_r[55:16]));
    case (mq_sh_r)
      SH16:    rsel = r16;
      SH24:    rsel = rs;
      SH33:    rsel = rs >> 9;
      default: rsel = rs;
    endcase
    rmag    = (rsel > 57'(MAX48_MAG)) ? MAX48_MAG : rsel[46:0];
    mq_comb = mq_a_r[47] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  end

  always_comb begin
    dd_abs  = dd_r[48] ? -50'(dd_r) : 50'(dd_r);
    pf_comb = sat48(58'(sat48(58'(dd_abs))) + $signed(58'({slew_r, 15'b0})));
    y_comb  = e_r[47] ? sat48(58'(sm_r[stg_r]) - $signed(58'(div_quo)))
                      : sat48(58'(sm_r[stg_r]) + $signed(58'(div_quo)));
    if (mq_res_r > CLAMP_LEVEL) begin
      w_clamp = CLAMP_LEVEL;
    end else if (mq_res_r < -CLAMP_LEVEL) begin
      w_clamp = -CLAMP_LEVEL;
    end else begin
      w_clamp = mq_res_r;
    end
    wq       = w_r >>> 2;
    b_term   = 32'(HALF32 - wq);
    pos_new  = (pos_r[stg_r] >> 1) + mq_res_r[31:0];
    z_full   = dneg_r ? ((58'(tap1_r) <<< 32) - $signed(58'(prod_r)))
                      : ((58'(tap1_r) <<< 32) + $signed(58'(prod_r)));
    z_comb   = 48'(z_full >>> 25);
    dry_comb = 48'(in_ch.sample_in) <<< 9;
    o_sh     = x_r >>> 9;
    i1       = wp_r[stg_r] - dly_r;
  end

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_r;
    mem_wd = '0;
    mem_ra = {stg_r, i1};
    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_W: begin
        mem_we = 1'b1;
        mem_wa = {stg_r, wp_r[stg_r]};
        mem_wd = 24'(w_clamp >>> 7);
      end
      ST_R2: begin
        mem_ra = {stg_r, DLY_W'(i1 - 1'b1)};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  assign div_start = (state_r == ST_E);
  assign div_num   = e_r[47] ? 48'(-e_r) : e_r;
  assign div_den   = 48'(pf_r) + ONE32;

  sadf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_r <= RST_SLEW_GAIN;
      ios_r  <= RST_INV_OUT_SLEW;
      isg_r  <= RST_INV_SLEW_GAIN;
      lvl_r  <= RST_LEVEL_GAIN;
      ilg_r  <= RST_INV_LEVEL_GAIN;
      wet_r  <= RST_WET_MIX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLEW_GAIN:      slew_r <= cfg_data[25:0];
        REG_INV_OUT_SLEW:   ios_r  <= cfg_data[25:0];
        REG_INV_SLEW_GAIN:  isg_r  <= cfg_data[25:0];
        REG_LEVEL_GAIN:     lvl_r  <= cfg_data[25:0];
        REG_INV_LEVEL_GAIN: ilg_r  <= cfg_data;
        REG_WET_MIX:        wet_r  <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ret_r       <= ST_IDLE;
      stg_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_STAGES; s++) begin
        last_in_r[s] <= '0;
        diff_r[s]    <= '0;
        sm_r[s]      <= '0;
        pos_r[s]     <= '0;
        wp_r[s]      <= DLY_W'(1);
      end
    end else begin
      // The output state reloads the output register itself.
      if (out_valid_r && out_ch.ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            dry_r   <= dry_comb;
            x_r     <= dry_comb;
            stg_r   <= '0;
            mq_a_r  <= dry_comb;
            mq_b_r  <= 32'(slew_r);
            mq_sh_r <= SH16;
            ret_r   <= ST_V;
            state_r <= ST_MA;
          end
        end
        ST_MA: begin
          hi_r    <= mul_p;
          state_r <= ST_MB;
        end
        ST_MB: begin
          lo_r    <= mul_p;
          state_r <= ST_MC;
        end
        ST_MC: begin
          mq_res_r <= mq_comb;
          state_r  <= ret_r;
        end
        ST_V: begin
          v_r              <= mq_res_r;
          nd_r             <= sat48(58'(mq_res_r) - 58'(last_in_r[stg_r]));
          last_in_r[stg_r] <= mq_res_r;
          state_r          <= ST_D;
        end
        ST_D: begin
          dd_r          <= 49'(nd_r) - 49'(diff_r[stg_r]);
          diff_r[stg_r] <= nd_r;
          state_r       <= ST_PF;
        end
        ST_PF: begin
          pf_r    <= pf_comb;
          mq_a_r  <= v_r;
          mq_b_r  <= (stg_r == STG_W'(NUM_STAGES - 1)) ? 32'(isg_r) : 32'(ios_r);
          mq_sh_r <= SH16;
          ret_r   <= ST_U;
          state_r <= ST_MA;
        end
        ST_U: begin
          e_r     <= sat48(58'(mq_res_r) - 58'(sm_r[stg_r]));
          state_r <= ST_E;
        end
        ST_E: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_Y;
          end
        end
        ST_Y: begin
          sm_r[stg_r] <= y_comb;
          mq_a_r      <= y_comb;
          mq_b_r      <= 32'(lvl_r);
          mq_sh_r     <= SH24;
          ret_r       <= ST_W;
          state_r     <= ST_MA;
        end
        ST_W: begin
          w_r     <= w_clamp;
          state_r <= ST_W2;
        end
        ST_W2: begin
          mq_a_r  <= w_r[47] ? -w_r : w_r;
          mq_b_r  <= b_term;
          mq_sh_r <= SH33;
          ret_r   <= ST_P;
          state_r <= ST_MA;
        end
        ST_P: begin
          pos_r[stg_r] <= pos_new;
          dly_r        <= pos_new[31 -: DLY_W];
          frac_r       <= pos_new << DLY_W;
          state_r      <= ST_R1;
        end
        ST_R1: begin
          state_r <= ST_R2;
        end
        ST_R2: begin
          tap1_r  <= rd_r;
          state_r <= ST_R3;
        end
        ST_R3: begin
          dif_r   <= 25'(rd_r) - 25'(tap1_r);
          state_r <= ST_I1;
        end
        ST_I1: begin
          dneg_r  <= dif_r[24];
          dmag_r  <= dif_r[24] ? 24'(-dif_r) : dif_r[23:0];
          state_r <= ST_I2;
        end
        ST_I2: begin
          prod_r  <= mul_p;
          state_r <= ST_I3;
        end
        ST_I3: begin
          wp_r[stg_r] <= wp_r[stg_r] + 1'b1;
          mq_a_r      <= z_comb;
          mq_b_r      <= ilg_r;
          mq_sh_r     <= SH16;
          ret_r       <= ST_NEXT;
          state_r     <= ST_MA;
        end
        ST_NEXT: begin
          x_r <= mq_res_r;
          if (stg_r != STG_W'(NUM_STAGES - 1)) begin
            stg_r   <= stg_r + 1'b1;
            mq_a_r  <= mq_res_r;
            mq_b_r  <= 32'(slew_r);
            mq_sh_r <= SH16;
            ret_r   <= ST_V;
            state_r <= ST_MA;
          end else if (!wet_r[16]) begin
            // Partial wet: blend the dry word back in.
            mq_a_r  <= dry_r;
            mq_b_r  <= 32'(17'h10000 - wet_r);
            mq_sh_r <= SH16;
            ret_r   <= ST_M1;
            state_r <= ST_MA;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_M1: begin
          m1_r    <= mq_res_r;
          mq_a_r  <= x_r;
          mq_b_r  <= 32'(wet_r);
          mq_sh_r <= SH16;
          ret_r   <= ST_M2;
          state_r <= ST_MA;
        end
        ST_M2: begin
          x_r     <= sat48(58'(m1_r) + 58'(mq_res_r));
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            if (o_sh > 48'sd8388607) begin
              out_data_r <= 24'sh7FFFFF;
            end else if (o_sh < -48'sd8388608) begin
              out_data_r <= 24'sh800000;
            end else begin
              out_data_r <= o_sh[23:0];
            end
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

endmodule
